@@ rtl/dht_pkg.sv @@
// Shared types and constants for the double-hashing table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dht_pkg;

    localparam int KEY_W        = 31;
    localparam int VALUE_W      = 32;
    localparam int SLOT_W       = 10;
    localparam int STATUS_W     = 3;
    localparam int DEF_TABLE    = 31;
    localparam int DEF_STEP_MOD = 23;
    localparam int DEF_QDEPTH   = 2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_FOUND = 3'd1,
        ST_MISS  = 3'd2,
        ST_DUP   = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    // Request after hashing: home slot and reduced stride travel with it.
    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  home;
        logic [SLOT_W-1:0]  stride;
    } t_job;

    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef enum logic [2:0] {
        F_IDLE = 3'd0,
        F_MUL  = 3'd1,
        F_RED  = 3'd2,
        F_FIX  = 3'd3,
        F_PUSH = 3'd4
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLEAR = 2'd0,
        B_IDLE  = 2'd1,
        B_PROBE = 2'd2
    } t_bstate;

endpackage

@@ rtl/dht_front.sv @@
// Front end: takes requests and works out home slot and probe stride
// with reciprocal-multiply constant remainders. Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_front import dht_pkg::*; #(
    parameter int TABLE_SIZE   = DEF_TABLE,
    parameter int STEP_MODULUS = DEF_STEP_MOD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_mode              i_mode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_push,
    output t_job               o_job,
    input  logic               i_full
);

    localparam int TW  = $clog2(TABLE_SIZE);
    localparam int SMW = $clog2(STEP_MODULUS);
    localparam int SW  = $clog2(STEP_MODULUS + 1);
    localparam int RW  = 32;
    localparam int MW  = KEY_W + RW;
    // floor(2^32 / M): the quotient estimate is exact or one short for any key
    localparam logic [RW-1:0] RECIP_T = RW'((64'd1 << RW) / 64'(TABLE_SIZE));
    localparam logic [RW-1:0] RECIP_S = RW'((64'd1 << RW) / 64'(STEP_MODULUS));

    t_fstate            r_state, n_state;
    logic               r_pass, n_pass;
    t_mode              r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [KEY_W-1:0]   r_opnd, n_opnd;
    logic [KEY_W-1:0]   r_quo_t, n_quo_t;
    logic [KEY_W-1:0]   r_quo_s, n_quo_s;
    logic [TW:0]        r_part_t, n_part_t;
    logic [SMW:0]       r_part_s, n_part_s;
    logic [TW-1:0]      r_home, n_home;
    logic [TW-1:0]      r_stride, n_stride;

    logic [MW-1:0]      prod_t;
    logic [MW-1:0]      prod_s;
    logic [TW:0]        fix_t;
    logic [TW-1:0]      rem_t;
    logic [SMW:0]       fix_s;
    logic [SMW-1:0]     rem_s;

    // Quotient estimate by reciprocal multiply; the partial remainder
    // then needs at most one compare-subtract.
    always_comb begin
        prod_t = MW'(r_opnd) * MW'(RECIP_T);
        prod_s = MW'(r_opnd) * MW'(RECIP_S);
        fix_t  = r_part_t;
        if (r_part_t >= (TW+1)'(TABLE_SIZE)) begin
            fix_t = r_part_t - (TW+1)'(TABLE_SIZE);
        end
        rem_t  = fix_t[TW-1:0];
        fix_s  = r_part_s;
        if (r_part_s >= (SMW+1)'(STEP_MODULUS)) begin
            fix_s = r_part_s - (SMW+1)'(STEP_MODULUS);
        end
        rem_s  = fix_s[SMW-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = (i_mode == MODE_NONE) ? F_PUSH : F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_RED;
            end
            F_RED: begin
                n_state = F_FIX;
            end
            F_FIX: begin
                n_state = r_pass ? F_PUSH : F_MUL;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        n_pass   = r_pass;
        n_mode   = r_mode;
        n_key    = r_key;
        n_value  = r_value;
        n_opnd   = r_opnd;
        n_quo_t  = r_quo_t;
        n_quo_s  = r_quo_s;
        n_part_t = r_part_t;
        n_part_s = r_part_s;
        n_home   = r_home;
        n_stride = r_stride;
        o_ready  = 1'b0;
        o_push   = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                n_pass  = 1'b0;
                n_mode  = i_mode;
                n_key   = i_key;
                n_value = i_value;
                n_opnd  = i_key;
            end
            F_MUL: begin
                n_quo_t = prod_t[MW-1:RW];
                n_quo_s = prod_s[MW-1:RW];
            end
            F_RED: begin
                n_part_t = (TW+1)'(r_opnd - KEY_W'(r_quo_t * KEY_W'(TABLE_SIZE)));
                n_part_s = (SMW+1)'(r_opnd - KEY_W'(r_quo_s * KEY_W'(STEP_MODULUS)));
            end
            F_FIX: begin
                // first pass gives home slot and step, second pass step mod TABLE_SIZE
                if (!r_pass) begin
                    n_pass = 1'b1;
                    n_home = rem_t;
                    n_opnd = KEY_W'(SW'(STEP_MODULUS) - SW'(rem_s));
                end else begin
                    n_stride = rem_t;
                end
            end
            F_PUSH: begin
                o_push = !i_full;
            end
            default: ;
        endcase
    end

    assign o_job = '{mode:   r_mode,
                     key:    r_key,
                     value:  r_value,
                     home:   SLOT_W'(r_home),
                     stride: SLOT_W'(r_stride)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pass   <= n_pass;
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_value  <= n_value;
        r_opnd   <= n_opnd;
        r_quo_t  <= n_quo_t;
        r_quo_s  <= n_quo_s;
        r_part_t <= n_part_t;
        r_part_s <= n_part_s;
        r_home   <= n_home;
        r_stride <= n_stride;
    end

endmodule

@@ rtl/dht_queue.sv @@
// Short FIFO of hashed requests between front and back end.
// Depends on dht_pkg for the request type.
`timescale 1ns / 1ps

module dht_queue import dht_pkg::*; #(
    parameter int DEPTH = DEF_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_slots [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slots[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        if (i_pop && !i_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) r_slots[r_wr] <= i_job;
    end

endmodule

@@ rtl/dht_back.sv @@
// Back end: table memory, probe walk and result register.
// Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_back import dht_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_found_value,
    output logic [SLOT_W-1:0]   o_slot
);

    localparam int TW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    t_entry             r_mem [TABLE_SIZE];
    t_entry             r_rd;
    t_bstate            r_state, n_state;
    t_job               r_job, n_job;
    logic [TW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_cnt, n_cnt;

    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_fval, n_fval;
    logic [SLOT_W-1:0]  r_slot, n_slot;

    logic               out_free;
    logic               hit, empty_slot, last, finish;
    logic [TW:0]        sum;
    logic [TW-1:0]      idx_step;
    logic [TW-1:0]      rd_addr;
    logic               we;
    logic [TW-1:0]      wr_addr;
    t_entry             wr_data;

    assign out_free   = !r_out_valid || i_ready;
    assign empty_slot = !r_rd.used;
    assign hit        = r_rd.used && (r_rd.key == r_job.key);
    assign last       = (r_cnt == CW'(TABLE_SIZE));
    assign finish     = empty_slot || hit || last;

    always_comb begin
        sum = {1'b0, r_idx} + {1'b0, TW'(r_job.stride)};
        if (sum >= (TW+1)'(TABLE_SIZE)) begin
            sum = sum - (TW+1)'(TABLE_SIZE);
        end
        idx_step = sum[TW-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_idx == TW'(TABLE_SIZE - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (o_pop && i_job.mode != MODE_NONE) n_state = B_PROBE;
            end
            B_PROBE: begin
                if (finish && out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_job       = r_job;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_fval      = r_fval;
        n_slot      = r_slot;
        o_pop       = 1'b0;
        rd_addr     = r_idx;
        we          = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '0;
        unique case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            B_IDLE: begin
                o_pop   = i_valid && (i_job.mode != MODE_NONE || out_free);
                n_job   = i_job;
                n_idx   = TW'(i_job.home);
                n_cnt   = '0;
                rd_addr = TW'(i_job.home);
                if (o_pop && i_job.mode == MODE_NONE) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_MISS;
                    n_fval      = '0;
                    n_slot      = '0;
                end
            end
            B_PROBE: begin
                if (!finish) begin
                    n_idx   = idx_step;
                    n_cnt   = r_cnt + 1'b1;
                    rd_addr = idx_step;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_fval      = '0;
                    n_slot      = '0;
                    priority if (empty_slot) begin
                        if (r_job.mode == MODE_INSERT) begin
                            we          = 1'b1;
                            wr_data     = '{used: 1'b1, key: r_job.key, value: r_job.value};
                            n_status    = ST_OK;
                            n_slot      = SLOT_W'(r_idx);
                        end else begin
                            n_status = ST_MISS;
                        end
                    end else if (hit) begin
                        unique case (r_job.mode)
                            MODE_INSERT: n_status = ST_DUP;
                            MODE_SEARCH: begin
                                n_status = ST_FOUND;
                                n_fval   = r_rd.value;
                                n_slot   = SLOT_W'(r_idx);
                            end
                            MODE_DELETE: begin
                                we       = 1'b1;
                                n_status = ST_OK;
                                n_slot   = SLOT_W'(r_idx);
                            end
                            default: n_status = ST_MISS;
                        endcase
                    end else begin
                        n_status = (r_job.mode == MODE_INSERT) ? ST_FULL : ST_MISS;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_job    <= n_job;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_fval   <= n_fval;
        r_slot   <= n_slot;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_slot        = r_slot;

endmodule

@@ rtl/double_hash_table.sv @@
// Open-addressing hash table with double hashing: insert, search, delete.
// Each request is hashed in two reciprocal-multiply passes and queued; the back end then
// probes the table, the last probe loading the result register. The unused mode skips both.
// The front end takes a new request only after pushing the last; the back end, with a single
// table read port, pops the next only when its walk ends. Results stall on m_axis_tready.
// Reset (sync, active low) starts a clear of every table slot; requests queue meanwhile.
`timescale 1ns / 1ps

module double_hash_table import dht_pkg::*; #(
    parameter int TABLE_SIZE   = DEF_TABLE,
    parameter int STEP_MODULUS = DEF_STEP_MOD,
    parameter int QUEUE_DEPTH  = DEF_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // mode[1:0], key[32:2], value[64:33], zero pad
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[2:0], found_value[34:3], slot[44:35], zero pad
);

    t_job                job_front;
    t_job                job_back;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    logic [STATUS_W-1:0] res_status;
    logic [VALUE_W-1:0]  res_fval;
    logic [SLOT_W-1:0]   res_slot;

    // Front end: transfer a request in, derive home slot and stride
    // (key mod TABLE_SIZE, and (STEP_MODULUS - key mod STEP_MODULUS) mod TABLE_SIZE).
    dht_front #(
        .TABLE_SIZE   (TABLE_SIZE),
        .STEP_MODULUS (STEP_MODULUS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (t_mode'(s_axis_tdata[1:0])),
        .i_key   (s_axis_tdata[32:2]),
        .i_value (s_axis_tdata[64:33]),
        .o_push  (q_push),
        .o_job   (job_front),
        .i_full  (q_full)
    );

    // Decouple hashing from probing so each side stalls on its own.
    dht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_front),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (job_back)
    );

    // Back end: walk the probe chain one slot per cycle, update the table,
    // hold the answer in the output register until it is taken.
    dht_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_job         (job_back),
        .o_pop         (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_status      (res_status),
        .o_found_value (res_fval),
        .o_slot        (res_slot)
    );

    assign m_axis_tdata = {3'b000, res_slot, res_fval, res_status};

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for double_hash_table: directed table rows, then random traffic.
// Models the probe walk of the table in-bench; depends on dht_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_top;
    import dht_pkg::*;

    localparam int TBL        = DEF_TABLE;
    localparam int STEP_MOD   = DEF_STEP_MOD;
    localparam int RAND_ITEMS = 1500;
    localparam int IDLE_LIMIT = 3000;   // cycles with no transfer on either side
    localparam int DRAIN_WAIT = 100;    // > worst request latency at default sizes
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] found;
        logic [SLOT_W-1:0]  slot;
    } answer_t;

    // One row of the directed table; pinned rows carry their answer, the rest use the model.
    typedef struct {
        t_mode              mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        bit                 pinned;
        answer_t            answer;
    } vector_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // mode[1:0], key[32:2], value[64:33], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // status[2:0], found_value[34:3], slot[44:35], zero pad

    // Model copy of the table contents.
    bit                 occupied [TBL] = '{default: 1'b0};
    logic [KEY_W-1:0]   stored_key [TBL];
    logic [VALUE_W-1:0] stored_val [TBL];

    answer_t          answers_due [$];
    logic [KEY_W-1:0] recent_keys [$];
    int               error_count = 0;
    int               idle_cycles = 0;
    int               stall_left  = 0;
    bit               steady      = 1'b0;   // stretch with no idling on either side
    answer_t          wanted;

    double_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk the probe sequence exactly as the table does and update the model copy.
    function automatic answer_t table_lookup(input t_mode m, input logic [KEY_W-1:0] k,
                                             input logic [VALUE_W-1:0] v);
        answer_t     a;
        int unsigned home;
        int unsigned stride;
        int unsigned offs;
        int unsigned idx;
        a.status = ST_MISS;
        a.found  = '0;
        a.slot   = '0;
        if (m == MODE_NONE)
            return a;
        home   = k % TBL;
        stride = (STEP_MOD - k % STEP_MOD) % TBL;
        offs   = 0;
        for (int i = 0; i <= TBL; i++) begin
            idx  = (home + offs) % TBL;
            offs = (offs + stride) % TBL;
            if (!occupied[idx]) begin
                // first empty slot ends the walk: insert lands here, lookups miss
                if (m == MODE_INSERT) begin
                    occupied[idx]   = 1'b1;
                    stored_key[idx] = k;
                    stored_val[idx] = v;
                    a.status = ST_OK;
                    a.slot   = SLOT_W'(idx);
                end
                return a;
            end
            if (stored_key[idx] == k) begin
                if (m == MODE_INSERT) begin
                    a.status = ST_DUP;
                end else if (m == MODE_SEARCH) begin
                    a.status = ST_FOUND;
                    a.found  = stored_val[idx];
                    a.slot   = SLOT_W'(idx);
                end else begin
                    // delete leaves no tombstone behind
                    occupied[idx] = 1'b0;
                    a.status = ST_OK;
                    a.slot   = SLOT_W'(idx);
                end
                return a;
            end
        end
        a.status = (m == MODE_INSERT) ? ST_FULL : ST_MISS;
        return a;
    endfunction

    // Mostly no gap, else a short one, now and then a long one; none in a steady stretch.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic vector_t vec(input t_mode m, input logic [KEY_W-1:0] k,
                                    input logic [VALUE_W-1:0] v, input bit pinned,
                                    input t_status st, input logic [VALUE_W-1:0] fv,
                                    input logic [SLOT_W-1:0] sl);
        vector_t r;
        r.mode          = m;
        r.key           = k;
        r.value         = v;
        r.pinned        = pinned;
        r.answer.status = st;
        r.answer.found  = fv;
        r.answer.slot   = sl;
        return r;
    endfunction

    // Present one request, hold it until the transfer, then queue its answer.
    task automatic push_request(input t_mode m, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v, input bit pinned,
                                input answer_t pinned_answer);
        int      gap;
        answer_t predicted;
        gap = pause_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, v, k, m};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = table_lookup(m, k, v);
        answers_due.push_back(pinned ? pinned_answer : predicted);
    endtask

    task automatic note_mismatch(input string field, input logic [VALUE_W-1:0] exp_val,
                                 input logic [VALUE_W-1:0] act_val);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val,
                     act_val);
    endtask

    // Receiver: random stalls on the result stream.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left    <= pause_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest answer due.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answers_due.size() == 0) begin
                error_count++;
                if (error_count <= MAX_PRINTS)
                    $display("%0t: result with no request pending, expected none, got %0h",
                             $time, m_axis_tdata);
            end else begin
                wanted = answers_due.pop_front();
                if (m_axis_tdata[2:0] !== wanted.status)
                    note_mismatch("status", 32'(wanted.status), 32'(m_axis_tdata[2:0]));
                if (m_axis_tdata[34:3] !== wanted.found)
                    note_mismatch("found_value", wanted.found, m_axis_tdata[34:3]);
                if (m_axis_tdata[44:35] !== wanted.slot)
                    note_mismatch("slot", 32'(wanted.slot), 32'(m_axis_tdata[44:35]));
                if (m_axis_tdata[47:45] !== 3'd0)
                    note_mismatch("pad", 32'd0, 32'(m_axis_tdata[47:45]));
            end
        end
    end

    // Watchdog: give up when neither stream moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        vector_t          directed [$];
        t_mode            m;
        logic [KEY_W-1:0] k;
        logic [VALUE_W-1:0] v;
        int               pick;
        bit               filling;

        // Directed table. Keys 0 and 31 share home slot 0; the max key lands in slot 1.
        directed.push_back(vec(MODE_SEARCH, '0, '0, 1, ST_MISS, '0, '0));   // empty table
        directed.push_back(vec(MODE_DELETE, '1, '1, 1, ST_MISS, '0, '0));
        directed.push_back(vec(MODE_INSERT, '0, '1, 1, ST_OK, '0, 10'd0));
        directed.push_back(vec(MODE_INSERT, '1, '0, 1, ST_OK, '0, 10'd1));
        directed.push_back(vec(MODE_INSERT, '0, 32'h1234, 1, ST_DUP, '0, '0));
        directed.push_back(vec(MODE_SEARCH, '0, '0, 1, ST_FOUND, '1, 10'd0));
        directed.push_back(vec(MODE_SEARCH, '1, '1, 1, ST_FOUND, '0, 10'd1));
        directed.push_back(vec(MODE_NONE, '0, '1, 1, ST_MISS, '0, '0));     // unused mode
        directed.push_back(vec(MODE_INSERT, 31'd31, 32'hA5A5_5A5A, 0, ST_OK, '0, '0));
        directed.push_back(vec(MODE_SEARCH, 31'd31, '0, 0, ST_OK, '0, '0));
        directed.push_back(vec(MODE_DELETE, '0, '0, 1, ST_OK, '0, 10'd0));
        // the cleared home slot cuts the chain to key 31
        directed.push_back(vec(MODE_SEARCH, 31'd31, '0, 1, ST_MISS, '0, '0));
        directed.push_back(vec(MODE_INSERT, 31'd31, 32'h0BAD_F00D, 1, ST_OK, '0, 10'd0));
        directed.push_back(vec(MODE_DELETE, 31'd31, '0, 1, ST_OK, '0, 10'd0));
        directed.push_back(vec(MODE_SEARCH, 31'd31, '0, 0, ST_OK, '0, '0));
        directed.push_back(vec(MODE_INSERT, 31'd62, 32'h5555_AAAA, 0, ST_OK, '0, '0));
        directed.push_back(vec(MODE_DELETE, '1, '0, 1, ST_OK, '0, 10'd1));
        directed.push_back(vec(MODE_SEARCH, '1, '0, 1, ST_MISS, '0, '0));
        directed.push_back(vec(MODE_NONE, '1, '1, 1, ST_MISS, '0, '0));
        directed.push_back(vec(MODE_DELETE, 31'd62, '0, 0, ST_OK, '0, '0));

        // hold reset, then release it once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n])
            push_request(directed[n].mode, directed[n].key, directed[n].value,
                         directed[n].pinned, directed[n].answer);

        // Random part: alternate fill-heavy and drain-heavy phases so the table
        // runs through long probe chains, full-table inserts and cut chains.
        filling = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) begin
                steady = ($urandom_range(0, 4) == 0);
                if (n % 100 == 0)
                    filling = !filling;
            end

            pick = $urandom_range(0, 99);
            if (filling)
                m = (pick < 65) ? MODE_INSERT : (pick < 85) ? MODE_SEARCH :
                    (pick < 96) ? MODE_DELETE : MODE_NONE;
            else
                m = (pick < 25) ? MODE_INSERT : (pick < 55) ? MODE_SEARCH :
                    (pick < 96) ? MODE_DELETE : MODE_NONE;

            pick = $urandom_range(0, 99);
            if (pick < 35 && recent_keys.size() != 0) begin
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            end else begin
                if (pick < 70)
                    k = KEY_W'($urandom_range(0, 40) * TBL + $urandom_range(0, 2));
                else if (pick < 90)
                    k = KEY_W'($urandom);
                else
                    case ($urandom_range(0, 2))
                        0:       k = '0;
                        1:       k = '1;
                        default: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(1, 64));
                    endcase
                recent_keys.push_back(k);
                if (recent_keys.size() > 48)
                    void'(recent_keys.pop_front());
            end

            pick = $urandom_range(0, 9);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : VALUE_W'($urandom);

            push_request(m, k, v, 1'b0, '0);
        end

        // drop valid and let every answer come back
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dht_pkg.sv
rtl/dht_front.sv
rtl/dht_queue.sv
rtl/dht_back.sv
rtl/double_hash_table.sv
test/tb_top.sv
